// ----- rtl/piecewise_linear_interpolator_defines.svh -----
// ----------------------------------------------------------------------------
// piecewise linear interpolator assertion macros
// clocked assertion helpers, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTH
`define PWLI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pwli assertion failed");
`define PWLI_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pwli assertion failed");
`else
`define PWLI_ASSERT(lbl, clk, rst_n, prop)
`define PWLI_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/pwli_pkg.sv -----
// ----------------------------------------------------------------------------
// pwli_pkg
// constants and codes shared by the interpolator files
// ----------------------------------------------------------------------------
package pwli_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOT_INCR = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

endpackage

// ----- rtl/pwli_req_if.sv -----
// ----------------------------------------------------------------------------
// pwli_req_if
// request channel: action and breakpoint or query coordinates
// ----------------------------------------------------------------------------
interface pwli_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] x_in;
	logic [31:0] y_in;

	modport source (output valid, output action, output x_in, output y_in, input ready);
	modport sink   (input valid, input action, input x_in, input y_in, output ready);
endinterface

// ----- rtl/pwli_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pwli_rsp_if
// response channel: interpolated value and status
// ----------------------------------------------------------------------------
interface pwli_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] y_out;
	logic [1:0]  status;

	modport source (output valid, output y_out, output status, input ready);
	modport sink   (input valid, input y_out, input status, output ready);
endinterface

// ----- rtl/piecewise_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// breakpoint table in one synchronous memory, linear scan and serial divide
// ----------------------------------------------------------------------------
// clear and append: the state goes straight to done, then the result loads the output register
// query: scan of the memory at one entry a cycle; a clamp ends there, else a prep step, one multiply,
// a 64-step restoring divide, then the add
// throughput: one beat at a time, next request taken once the result is out
// reset: point count cleared at once; memory contents undefined, never cleared
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_defines.svh"

module piecewise_linear_interpolator (
	input logic          clk,
	input logic          arst_n,
	pwli_req_if.sink     req,
	pwli_rsp_if.source   rsp
);
	import pwli_pkg::*;

	// one-hot sequencer
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_PREP = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_ADD  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// breakpoint memory, {x, y} per entry, read data registered
	logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
	logic [2*DATA_W-1:0] rdata_s1;
	logic                cmp_vld_s1;
	logic [CNT_W-1:0]    cmp_idx_s1;

	logic [CNT_W-1:0]    cnt_q;       // stored breakpoints
	logic [DATA_W-1:0]   last_x_q;    // x of the newest breakpoint
	logic [CNT_W-1:0]    scan_idx_q;  // next entry to read

	logic [DATA_W-1:0]   xq_q;
	logic [DATA_W-1:0]   x0_q, y0_q, x1_q, y1_q;
	logic [DATA_W-1:0]   dx_q, den_q, ady_q;
	logic                neg_q;
	logic [2*DATA_W-1:0] prod_q;      // product, then quotient shifts in
	logic [DATA_W-1:0]   rem_q;
	logic [5:0]          div_cnt_q;

	logic [DATA_W-1:0]   res_y_q;
	status_t             res_st_q;

	logic                out_vld_q;
	logic [DATA_W-1:0]   out_y_q;
	status_t             out_st_q;

	logic                req_acc;
	logic                wr_en;
	logic                rd_issue;
	logic                load_out;
	logic [DATA_W-1:0]   rx, ry;
	logic                hit;
	logic [DATA_W:0]     trial;
	logic                trial_ge;
	logic [DATA_W:0]     dy_w;
	logic [DATA_W:0]     dx_w;
	logic [DATA_W:0]     den_w;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	// result moves to the output register once that register is free
	assign load_out = (state_q == S_DONE) && (!out_vld_q || rsp.ready);

	// the table is written only from idle and read only while scanning,
	// so a write never overlaps a read of the same entry
	assign wr_en = req_acc && (action_t'(req.action) == ACT_APPEND)
		&& (cnt_q != CNT_W'(TABLE_DEPTH))
		&& !((cnt_q != '0) && ($signed(req.x_in) <= $signed(last_x_q)));

	assign rd_issue = (state_q == S_SCAN) && (scan_idx_q < cnt_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= {req.x_in, req.y_in};
		end
		if (rd_issue) begin
			rdata_s1 <= mem[scan_idx_q[IDX_W-1:0]];
		end
	end

	assign rx  = rdata_s1[2*DATA_W-1:DATA_W];
	assign ry  = rdata_s1[DATA_W-1:0];
	// first breakpoint whose x is not below the query
	assign hit = $signed(rx) >= $signed(xq_q);

	// one restoring divide step
	assign trial    = {rem_q, prod_q[2*DATA_W-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	// segment differences, one bit wider so they cannot wrap
	assign dx_w  = {xq_q[DATA_W-1], xq_q} - {x0_q[DATA_W-1], x0_q};
	assign den_w = {x1_q[DATA_W-1], x1_q} - {x0_q[DATA_W-1], x0_q};
	assign dy_w  = {y1_q[DATA_W-1], y1_q} - {y0_q[DATA_W-1], y0_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_issue;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						res_y_q  <= '0;
						res_st_q <= ST_OK;
						xq_q     <= req.x_in;
						state_q  <= S_DONE;
						case (action_t'(req.action))
							ACT_CLEAR: begin
								cnt_q <= '0;
							end
							ACT_APPEND: begin
								if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
									res_st_q <= ST_FULL;
								end else if (!wr_en) begin
									res_st_q <= ST_NOT_INCR;
								end else begin
									cnt_q    <= cnt_q + CNT_W'(1);
									last_x_q <= req.x_in;
								end
							end
							ACT_QUERY: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_EMPTY;
								end else begin
									scan_idx_q <= '0;
									state_q    <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (cmp_vld_s1) begin
						if (hit) begin
							if (cmp_idx_s1 == '0) begin
								// at or below the first x: clamp
								res_y_q <= ry;
								state_q <= S_DONE;
							end else begin
								x1_q    <= rx;
								y1_q    <= ry;
								state_q <= S_PREP;
							end
						end else if (cmp_idx_s1 == cnt_q - CNT_W'(1)) begin
							// beyond the last x: clamp
							res_y_q <= ry;
							state_q <= S_DONE;
						end else begin
							x0_q <= rx;
							y0_q <= ry;
						end
					end
				end
				S_PREP: begin
					dx_q    <= dx_w[DATA_W-1:0];
					den_q   <= den_w[DATA_W-1:0];
					neg_q   <= dy_w[DATA_W];
					ady_q   <= dy_w[DATA_W] ? DATA_W'(-dy_w) : dy_w[DATA_W-1:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q    <= {{DATA_W{1'b0}}, dx_q} * {{DATA_W{1'b0}}, ady_q};
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= trial_ge ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
					prod_q    <= {prod_q[2*DATA_W-2:0], trial_ge};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					// quotient is at most |dy|, so the sum stays in range
					res_y_q <= neg_q ? (y0_q - prod_q[DATA_W-1:0])
						: (y0_q + prod_q[DATA_W-1:0]);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_y_q   <= res_y_q;
						out_st_q  <= res_st_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q;
	end

	assign rsp.valid  = out_vld_q;
	assign rsp.y_out  = out_y_q;
	assign rsp.status = out_st_q;

	// point count never passes the table depth
	`PWLI_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(TABLE_DEPTH))
	// an append to a full table leaves the count alone
	`PWLI_ASSERT(a_full_hold, clk, arst_n, req_acc && (action_t'(req.action) == ACT_APPEND) && (cnt_q == CNT_W'(TABLE_DEPTH)) |=> cnt_q == CNT_W'(TABLE_DEPTH))
	// the scan never reads past the stored points
	`PWLI_ASSERT(a_scan_bound, clk, arst_n, cmp_vld_s1 |-> cmp_idx_s1 < cnt_q)

endmodule

// ----- tb/sv/piecewise_linear_interpolator_test.sv -----
// ----------------------------------------------------------------------------
// piecewise linear interpolator testbench
// directed table of clear, append, query and unused-code beats, a full table, then random tables
// with random query points; every response is checked against a local model of the breakpoint
// table or a typed-in answer, with random idling on both channels
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pwli_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	// one request beat and, for directed rows, an optional typed-in answer
	typedef struct {
		action_t     act;
		logic [31:0] x;
		logic [31:0] y;
		bit          fixed;
		logic [31:0] y_exp;
		status_t     st_exp;
	} stim_row_t;

	typedef struct {
		logic [31:0] y;
		status_t     st;
	} answer_t;

	logic clk;
	logic arst_n;

	pwli_req_if req ();
	pwli_rsp_if rsp ();

	piecewise_linear_interpolator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// local copy of the breakpoint table
	logic signed [31:0] bp_x [TABLE_DEPTH];
	logic signed [31:0] bp_y [TABLE_DEPTH];
	int unsigned        bp_count;

	answer_t     pending_answers [$];
	int unsigned mismatch_count;
	int unsigned beats_sent;
	int unsigned beats_checked;
	int unsigned queries_sent;
	int unsigned full_rejects;
	int unsigned cycle_count;
	bit          stim_done;

	stim_row_t directed [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// linear interpolation between bracketing breakpoints, truncated quotient
	function automatic logic [31:0] interp_value(logic signed [31:0] xq);
		int unsigned    last;
		int unsigned    i;
		longint         dy;
		longint         x0;
		logic [63:0]    dx;
		logic [63:0]    den;
		logic [63:0]    mag;
		logic [63:0]    quo;
		logic [63:0]    dy_abs;
		longint         res;
		last = bp_count - 1;
		if (xq <= bp_x[0])
			return bp_y[0];
		if (xq >= bp_x[last])
			return bp_y[last];
		i = 1;
		while (i < last && bp_x[i] < xq)
			i++;
		x0 = bp_x[i - 1];
		dx = 64'(longint'(xq) - x0);
		den = 64'(longint'(bp_x[i]) - x0);
		dy = longint'(bp_y[i]) - longint'(bp_y[i - 1]);
		dy_abs = (dy < 0) ? 64'(-dy) : 64'(dy);
		mag = dx * dy_abs;
		quo = mag / den;
		if (dy < 0)
			res = longint'(bp_y[i - 1]) - longint'(quo);
		else
			res = longint'(bp_y[i - 1]) + longint'(quo);
		return res[31:0];
	endfunction

	// advance the table model by one request beat and give its answer
	function automatic answer_t table_step(action_t act, logic [31:0] x, logic [31:0] y);
		answer_t a;
		a.y = '0;
		a.st = ST_OK;
		case (act)
			ACT_CLEAR: begin
				bp_count = 0;
			end
			ACT_APPEND: begin
				if (bp_count >= TABLE_DEPTH) begin
					a.st = ST_FULL;
					full_rejects++;
				end else if (bp_count > 0 && $signed(x) <= bp_x[bp_count - 1]) begin
					a.st = ST_NOT_INCR;
				end else begin
					bp_x[bp_count] = x;
					bp_y[bp_count] = y;
					bp_count++;
				end
			end
			ACT_QUERY: begin
				if (bp_count == 0)
					a.st = ST_EMPTY;
				else
					a.y = interp_value(x);
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s at beat %0d: got %h expected %h", what, beats_checked,
			got, want);
		mismatch_count++;
	endtask

	// drive one request beat after a random gap, record what it should give;
	// returns at the accepting edge with valid still high, so a beat with no
	// gap follows straight on at the next falling edge
	task automatic send_beat(stim_row_t row);
		answer_t a;
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		@(negedge clk);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= row.act;
		req.x_in <= row.x;
		req.y_in <= row.y;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		a = table_step(row.act, row.x, row.y);
		if (row.fixed && (a.y !== row.y_exp || a.st !== row.st_exp))
			report_mismatch("directed table entry", {a.y[29:0], a.st}, {row.y_exp[29:0],
				row.st_exp});
		if (row.fixed) begin
			a.y = row.y_exp;
			a.st = row.st_exp;
		end
		pending_answers.push_back(a);
		beats_sent++;
		if (row.act == ACT_QUERY)
			queries_sent++;
	endtask

	function automatic stim_row_t mk(action_t act, logic [31:0] x, logic [31:0] y);
		stim_row_t r;
		r.act = act;
		r.x = x;
		r.y = y;
		r.fixed = 1'b0;
		r.y_exp = '0;
		r.st_exp = ST_OK;
		return r;
	endfunction

	function automatic stim_row_t mk_fixed(action_t act, logic [31:0] x, logic [31:0] y,
			logic [31:0] ye, status_t se);
		stim_row_t r;
		r = mk(act, x, y);
		r.fixed = 1'b1;
		r.y_exp = ye;
		r.st_exp = se;
		return r;
	endfunction

	// drop valid, then wait until every expected answer has come back
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
	endtask

	// random well-formed table, random increasing x, then queries, rejected appends, unused codes
	task automatic random_table_round(int npts, int nq);
		logic signed [31:0] xs;
		logic signed [31:0] step;
		int k;
		send_beat(mk(ACT_CLEAR, $urandom, $urandom));
		xs = (npts > 1 && $urandom_range(0, 1)) ? 32'sh8000_0000 : $signed($urandom);
		for (k = 0; k < npts; k++) begin
			send_beat(mk(ACT_APPEND, xs, $urandom));
			step = ($urandom_range(0, 2) == 0) ? $signed($urandom_range(1, 4)) :
				$signed($urandom_range(1, 32'h7fff_ffff / (npts + 1)));
			if ($signed(xs) > 32'sh7fff_ffff - step)
				break;
			xs = xs + step;
		end
		for (k = 0; k < nq; k++) begin
			case ($urandom_range(0, 9))
				0: send_beat(mk(ACT_APPEND, bp_x[bp_count - 1] - $urandom_range(0, 3),
					$urandom));
				1: send_beat(mk(ACT_QUERY, $urandom, $urandom));
				2: send_beat(mk(ACT_NONE, $urandom, $urandom));
				3: send_beat(mk(ACT_QUERY, bp_x[$urandom_range(0, bp_count - 1)], $urandom));
				default: begin
					int i;
					i = $urandom_range(0, bp_count - 1);
					send_beat(mk(ACT_QUERY, bp_x[i] + $urandom_range(0, 40000), $urandom));
				end
			endcase
		end
	endtask

	// request side
	initial begin
		int k;
		req.valid = 1'b0;
		req.action = ACT_CLEAR;
		req.x_in = '0;
		req.y_in = '0;
		arst_n = 1'b0;
		stim_done = 1'b0;
		bp_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, unused code, clamps, one point, order rejects, extremes
		directed.push_back(mk_fixed(ACT_QUERY, 32'h0, 32'hffff_ffff, 32'h0, ST_EMPTY));
		directed.push_back(mk_fixed(ACT_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'h0, ST_OK));
		directed.push_back(mk_fixed(ACT_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h0, ST_OK));
		directed.push_back(mk_fixed(ACT_QUERY, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, ST_OK));
		directed.push_back(mk_fixed(ACT_APPEND, 32'h8000_0000, 32'h0, 32'h0, ST_NOT_INCR));
		directed.push_back(mk_fixed(ACT_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h0, ST_OK));
		directed.push_back(mk_fixed(ACT_QUERY, 32'h8000_0000, 32'h0, 32'h7fff_ffff, ST_OK));
		directed.push_back(mk_fixed(ACT_QUERY, 32'h7fff_ffff, 32'h0, 32'h8000_0000, ST_OK));
		directed.push_back(mk(ACT_QUERY, 32'h0, 32'h0));
		directed.push_back(mk(ACT_QUERY, 32'hffff_ffff, 32'h0));
		directed.push_back(mk(ACT_QUERY, 32'h8000_0001, 32'h0));
		directed.push_back(mk(ACT_QUERY, 32'h7fff_fffe, 32'h0));
		directed.push_back(mk_fixed(ACT_APPEND, 32'h7fff_ffff, 32'h1, 32'h0, ST_NOT_INCR));
		directed.push_back(mk_fixed(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'h0, ST_OK));
		directed.push_back(mk_fixed(ACT_QUERY, 32'h1234, 32'h0, 32'h0, ST_EMPTY));
		directed.push_back(mk(ACT_APPEND, 32'h0001_0000, 32'h0002_0000));
		directed.push_back(mk(ACT_APPEND, 32'h0003_0000, 32'hfffe_0000));
		directed.push_back(mk(ACT_APPEND, 32'h0003_0001, 32'h0005_0000));
		directed.push_back(mk(ACT_QUERY, 32'h0002_0000, 32'h0));
		directed.push_back(mk(ACT_QUERY, 32'h0001_7fff, 32'h0));
		directed.push_back(mk(ACT_QUERY, 32'h0003_0000, 32'h0));
		directed.push_back(mk(ACT_QUERY, 32'h0000_ffff, 32'h0));
		directed.push_back(mk(ACT_QUERY, 32'h0003_0002, 32'h0));
		foreach (directed[i])
			send_beat(directed[i]);

		// fill the table to the brim, then append past the end
		drain();
		send_beat(mk(ACT_CLEAR, 32'h0, 32'h0));
		for (k = 0; k < TABLE_DEPTH; k++)
			send_beat(mk(ACT_APPEND, 32'h8000_0000 + k * 32'h0100_0000 + $urandom_range(0, 255),
				$urandom));
		send_beat(mk(ACT_APPEND, 32'h7fff_ffff, 32'h0));
		send_beat(mk(ACT_APPEND, 32'h0, 32'h0));
		for (k = 0; k < 10; k++)
			send_beat(mk(ACT_QUERY, $urandom, $urandom));

		// pause the request side until all answers are back
		drain();

		// random tables, mostly short to keep the scan brief
		while (beats_sent < 600) begin
			random_table_round(($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) :
				$urandom_range(1, 6), $urandom_range(3, 12));
			if ($urandom_range(0, 5) == 0)
				drain();
		end
		drain();
		stim_done = 1'b1;
	end

	// response side: random stall per beat, checked against the oldest answer
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			@(negedge clk);
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid)
				@(posedge clk);
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected response beat", rsp.y_out, 32'h0);
			end else begin
				answer_t a;
				a = pending_answers.pop_front();
				if (rsp.y_out !== a.y)
					report_mismatch("y_out", rsp.y_out, a.y);
				if (rsp.status !== a.st)
					report_mismatch("status", 32'(rsp.status), 32'(a.st));
			end
			beats_checked++;
		end
	end

	// end of run and cycle limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("Verification failed");
				$finish;
			end
			if (stim_done && pending_answers.size() == 0) begin
				repeat (TABLE_DEPTH + 80) @(posedge clk);
				$display("%0d request beats, %0d queries, %0d rejects on a full table", beats_sent,
					queries_sent, full_rejects);
				$display("%0d response beats checked, %0d mismatches", beats_checked,
					mismatch_count);
				if (mismatch_count == 0)
					$display("Verification passed");
				else
					$display("Verification failed");
				$finish;
			end
		end
	end

endmodule
